### hdl/nggd_pkg.sv
// shared constants, types and the wobble sine table of the needle gauge driver
`default_nettype none

package nggd_pkg;

    // block constants
    localparam int LEVELS      = 12;
    localparam int PWM_BITS    = 10;
    localparam int PHASE_STEPS = 20;
    localparam int FRAC_BITS   = 16;

    // field and register widths
    localparam int FUNC_W  = 2;
    localparam int WAIT_W  = 8;
    localparam int STEP_W  = 16;
    localparam int LAG_W   = 18;
    localparam int CFG_W   = 18;
    localparam int CFG_AW  = 1;
    localparam int LEVEL_W = $clog2(LEVELS + 1);
    localparam int PHASE_W = $clog2(PHASE_STEPS);
    localparam int VAL_W   = 25;
    localparam int SUM_W   = VAL_W + 1;
    localparam int SINE_W  = FRAC_BITS + 1;
    localparam int CLAMP_W = LEVEL_W + FRAC_BITS;
    localparam int LWAIT_W = WAIT_W + 1;
    localparam int DIFF_W  = PWM_BITS + 1;
    localparam int PROD_W  = DIFF_W + FRAC_BITS + 1;

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WAIT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CAL  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_STEP = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_LAG  = 1'b1;

    // reset values
    localparam logic [STEP_W-1:0] STEP_RST  = STEP_W'(109);
    localparam logic [LAG_W-1:0]  LAG_RST   = LAG_W'(98304);
    localparam logic [PHASE_W-1:0] PHASE_START = PHASE_W'((3 * PHASE_STEPS) / 4);

    typedef logic signed [VAL_W-1:0]   t_val;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [SINE_W-1:0]  t_sine;
    typedef logic signed [LWAIT_W-1:0] t_lwait;

    localparam t_val   HALF_V = t_val'(1) <<< (FRAC_BITS - 1);
    localparam t_sum   TOP_V  = SUM_W'(LEVELS << FRAC_BITS);
    localparam t_lwait NO_WAIT = '1;

    // half-amplitude sine, round(2^(FRAC_BITS-1) * sin(2*pi*k/PHASE_STEPS))
    function automatic t_sine sine_at(input logic [PHASE_W-1:0] k);
        t_sine s;
        case (k)
            5'd0:    s =  17'sd0;
            5'd1:    s =  17'sd10126;
            5'd2:    s =  17'sd19261;
            5'd3:    s =  17'sd26510;
            5'd4:    s =  17'sd31164;
            5'd5:    s =  17'sd32768;
            5'd6:    s =  17'sd31164;
            5'd7:    s =  17'sd26510;
            5'd8:    s =  17'sd19261;
            5'd9:    s =  17'sd10126;
            5'd10:   s =  17'sd0;
            5'd11:   s = -17'sd10126;
            5'd12:   s = -17'sd19261;
            5'd13:   s = -17'sd26510;
            5'd14:   s = -17'sd31164;
            5'd15:   s = -17'sd32768;
            5'd16:   s = -17'sd31164;
            5'd17:   s = -17'sd26510;
            5'd18:   s = -17'sd19261;
            5'd19:   s = -17'sd10126;
            default: s =  17'sd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### hdl/nggd_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module nggd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/needle_gauge_countdown_driver_core.sv
// top level of the needle gauge countdown driver: state update, lookup and interpolation
`default_nettype none

// Needle gauge countdown driver. Items arrive on a valid/ready channel: a tick
// lowers the shown minute value while counting down and gives one result beat
// (pwm duty plus the wobbling and counting-down flags), a wait report restarts
// the display when it differs from the stored wait, and a calibration write
// fills one of the LEVELS+1 duty marks. Wait reports and calibration writes give
// no result. One item is accepted every cycle unless the lookup stage stalls;
// a tick's state update and table read are registered at its acceptance, and the
// interpolation product goes into the result register once that is free.
// The calibration table sits in two small RAM copies, one per read port (lower
// and upper mark), with a valid bit per entry so that reset reads all marks as
// zero without a clearing pass. The lookup stage lets a new item in while a
// result waits to be taken, if it is empty. Configuration writes take effect
// at once and are meant for idle periods.

module needle_gauge_countdown_driver_core
    import nggd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_AW-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    // item channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [FUNC_W-1:0]   i_func,
    input  wire logic [WAIT_W-1:0]   i_wait_minutes,
    input  wire logic                i_wait_valid,
    input  wire logic [LEVEL_W-1:0]  i_cal_index,
    input  wire logic [PWM_BITS-1:0] i_cal_duty,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [PWM_BITS-1:0]      o_pwm_duty,
    output logic                     o_wobbling,
    output logic                     o_counting_down
);

    // configuration registers
    logic [STEP_W-1:0] r_step;
    logic [LAG_W-1:0]  r_lag;

    // display state
    t_val               r_shown, n_shown;
    t_lwait             r_last_wait, n_last_wait;
    logic               r_wob, n_wob;
    logic               r_cd, n_cd;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [LEVELS:0]    r_cal_vld;

    // lookup stage
    logic                 r_s1_vld;
    logic [FRAC_BITS-1:0] r_s1_frac;
    logic                 r_s1_wob;
    logic                 r_s1_cd;
    logic                 r_lo_vld;
    logic                 r_hi_vld;

    // result register
    logic                r_out_vld;
    logic [PWM_BITS-1:0] r_out_duty;
    logic                r_out_wob;
    logic                r_out_cd;

    logic accept;
    logic s1_adv;
    logic is_tick;
    logic cal_we;

    logic [LEVEL_W-1:0]   lo_idx;
    logic [LEVEL_W-1:0]   hi_idx;
    logic [FRAC_BITS-1:0] frac;
    logic [PWM_BITS-1:0]  lo_rdata;
    logic [PWM_BITS-1:0]  hi_rdata;

    // handshake: the lookup stage moves on whenever the result register is free
    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign accept     = i_in_valid && o_in_ready;
    assign is_tick    = accept && (i_func == FUNC_TICK);
    assign cal_we     = accept && (i_func == FUNC_CAL) &&
                        (i_cal_index <= LEVEL_W'(LEVELS));

    // state update for the accepted item, and lookup addresses for a tick
    always_comb begin
        t_sum               wait_fx;
        t_sum               dec;
        t_sum               lim;
        t_sum               v;
        t_lwait             wait_new;
        logic [PHASE_W-1:0] p;
        logic [CLAMP_W-1:0] cv;

        n_shown     = r_shown;
        n_last_wait = r_last_wait;
        n_wob       = r_wob;
        n_cd        = r_cd;
        n_phase     = r_phase;
        wait_fx     = SUM_W'($unsigned(r_last_wait[WAIT_W-1:0])) <<< FRAC_BITS;
        dec         = SUM_W'(r_shown) - SUM_W'(r_step);
        lim         = wait_fx - SUM_W'(r_lag);
        wait_new    = i_wait_valid ? t_lwait'({1'b0, i_wait_minutes}) : NO_WAIT;
        p           = '0;
        v           = '0;
        cv          = '0;

        if (accept) begin
            unique case (i_func)
                FUNC_TICK: begin
                    // countdown; falling too far behind the wait starts the wobble
                    if (r_cd) begin
                        if (dec < lim) begin
                            n_cd    = 1'b0;
                            n_wob   = 1'b1;
                            n_shown = VAL_W'(wait_fx);
                            n_phase = PHASE_START;
                        end else begin
                            n_shown = VAL_W'(dec);
                        end
                    end
                    v = SUM_W'(n_shown);
                    if (n_wob) begin
                        p       = (n_phase >= PHASE_W'(PHASE_STEPS)) ? '0 : n_phase;
                        v       = v + SUM_W'(sine_at(p));
                        n_phase = (p == PHASE_W'(PHASE_STEPS - 1)) ? '0 : p + PHASE_W'(1);
                    end else begin
                        n_phase = '0;
                    end
                end
                FUNC_WAIT: begin
                    // only a changed report restarts the display
                    if (wait_new != r_last_wait) begin
                        n_last_wait = wait_new;
                        if (i_wait_valid) begin
                            n_shown = t_val'(wait_new) <<< FRAC_BITS;
                            n_cd    = 1'b1;
                            n_wob   = 1'b0;
                        end else begin
                            n_shown = HALF_V;
                            n_wob   = 1'b1;
                            n_cd    = 1'b0;
                        end
                    end
                end
                FUNC_CAL: begin
                end
                default: begin
                end
            endcase
        end

        // clamp to the meter range
        if (v < 0) begin
            cv = '0;
        end else if (v > TOP_V) begin
            cv = CLAMP_W'(TOP_V);
        end else begin
            cv = CLAMP_W'(v);
        end

        lo_idx = cv[CLAMP_W-1:FRAC_BITS];
        frac   = cv[FRAC_BITS-1:0];
        // upper mark; lo is only LEVELS when the fraction is zero, so hi stays in range
        hi_idx = lo_idx + LEVEL_W'(frac != '0);
    end

    // calibration marks, one copy per read port
    nggd_ram #(
        .WIDTH (PWM_BITS),
        .DEPTH (LEVELS + 1)
    ) u_cal_lo (
        .i_clk   (i_clk),
        .i_we    (cal_we),
        .i_waddr (i_cal_index),
        .i_wdata (i_cal_duty),
        .i_re    (is_tick),
        .i_raddr (lo_idx),
        .o_rdata (lo_rdata)
    );

    nggd_ram #(
        .WIDTH (PWM_BITS),
        .DEPTH (LEVELS + 1)
    ) u_cal_hi (
        .i_clk   (i_clk),
        .i_we    (cal_we),
        .i_waddr (i_cal_index),
        .i_wdata (i_cal_duty),
        .i_re    (is_tick),
        .i_raddr (hi_idx),
        .o_rdata (hi_rdata)
    );

    // state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_RST;
            r_lag       <= LAG_RST;
            r_shown     <= HALF_V;
            r_last_wait <= NO_WAIT;
            r_wob       <= 1'b1;
            r_cd        <= 1'b0;
            r_phase     <= '0;
            r_cal_vld   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STEP: r_step <= i_cfg_data[STEP_W-1:0];
                    CFG_LAG:  r_lag  <= i_cfg_data[LAG_W-1:0];
                    default:  r_step <= r_step;
                endcase
            end
            r_shown     <= n_shown;
            r_last_wait <= n_last_wait;
            r_wob       <= n_wob;
            r_cd        <= n_cd;
            r_phase     <= n_phase;
            if (cal_we) begin
                r_cal_vld[i_cal_index] <= 1'b1;
            end
        end
    end

    // lookup stage: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= is_tick;
        end
    end

    // lookup stage: payload, held with the ram read data while stalled
    always_ff @(posedge i_clk) begin
        if (is_tick) begin
            r_s1_frac <= frac;
            r_s1_wob  <= n_wob;
            r_s1_cd   <= n_cd;
            // a mark never written reads as zero
            r_lo_vld  <= r_cal_vld[lo_idx];
            r_hi_vld  <= r_cal_vld[hi_idx];
        end
    end

    // interpolation between the two marks, truncated
    logic [PWM_BITS-1:0]      pl;
    logic [PWM_BITS-1:0]      ph;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] total;

    always_comb begin
        pl    = r_lo_vld ? lo_rdata : '0;
        ph    = r_hi_vld ? hi_rdata : '0;
        diff  = DIFF_W'(ph) - DIFF_W'(pl);
        prod  = PROD_W'(diff) * PROD_W'(signed'({1'b0, r_s1_frac}));
        total = (PROD_W'(pl) <<< FRAC_BITS) + prod;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_duty <= total[FRAC_BITS +: PWM_BITS];
            r_out_wob  <= r_s1_wob;
            r_out_cd   <= r_s1_cd;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_pwm_duty      = r_out_duty;
    assign o_wobbling      = r_out_wob;
    assign o_counting_down = r_out_cd;

endmodule

`default_nettype wire
